// ===== sv/multiplexed_seven_segment_scanner_core_defines.svh =====
// Assertion macros for the checker file of the display scanner.
// Stand-alone header: no dependencies.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define MSSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MSSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/msss_pkg.sv =====
// Shared types, constants and digit helpers for the seven-segment scanner.
// No dependencies; used by msss_digit_sel and the top level.
`timescale 1ns / 1ps

package msss_pkg;

    // Word kinds on the input channel
    localparam logic [1:0] KIND_SET  = 2'd0;
    localparam logic [1:0] KIND_OFF  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Largest value the display can show
    localparam logic [9:0] MAX_SHOWN = 10'd999;

    // Number of scanned digit positions (1 to 3)
    localparam logic [1:0] DIGIT_COUNT = 2'd3;

    // Scan positions
    localparam logic [1:0] POS_UNITS = 2'd0;
    localparam logic [1:0] POS_TENS  = 2'd1;

    // Digit drive codes
    localparam logic [2:0] EN_UNITS    = 3'b001;
    localparam logic [2:0] EN_TENS     = 3'b010;
    localparam logic [2:0] EN_HUNDREDS = 3'b100;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [6:0] rem;
    } hund_split_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } tens_split_t;

    // Result of the per-tick digit selection
    typedef struct packed {
        logic       lit;
        logic [2:0] enable;
        logic [6:0] seg;
    } digit_sel_t;

    // Active-low glyphs: bits 0-5 are a-f, bit 6 is g
    function automatic logic [6:0] seg_lookup(input logic [3:0] digit);
        logic [6:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h40;
            4'd1:    seg = 7'h79;
            4'd2:    seg = 7'h24;
            4'd3:    seg = 7'h30;
            4'd4:    seg = 7'h19;
            4'd5:    seg = 7'h12;
            4'd6:    seg = 7'h02;
            4'd7:    seg = 7'h78;
            4'd8:    seg = 7'h00;
            4'd9:    seg = 7'h10;
            default: seg = 7'h40;
        endcase
        return seg;
    endfunction

    // Hundreds digit and remainder of a value up to 999 (parallel compares)
    function automatic hund_split_t split_hundreds(input logic [9:0] value);
        hund_split_t res;
        res.hundreds = 4'd0;
        res.rem      = value[6:0];
        for (int k = 1; k <= 9; k++) begin
            if (value >= 10'(k * 100)) begin
                res.hundreds = 4'(k);
                res.rem      = 7'(value - 10'(k * 100));
            end
        end
        return res;
    endfunction

    // Tens and units digits of a remainder below 100
    function automatic tens_split_t split_tens(input logic [6:0] rem);
        tens_split_t res;
        res.tens  = 4'd0;
        res.units = rem[3:0];
        for (int k = 1; k <= 9; k++) begin
            if (rem >= 7'(k * 10)) begin
                res.tens  = 4'(k);
                res.units = 4'(rem - 7'(k * 10));
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/multiplexed_seven_segment_scanner_core.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   kind[1:0], number[9:0]
// output    out        out_valid/out_stall segments[6:0], digit_enable[2:0]
//
// One word per cycle sustained while the output is not stalled; a taken word passes
// through the input register, then one pass of digit logic into the result register.
// Set words give no result; off and tick words give one each; kind 3 is dropped.
// A stall on the output holds the result register, and the input stalls only
// while a result-producing word waits in the input register behind it.
// Reset clears the stored value, disables the display and returns the scan to units.
// Depends on msss_pkg and msss_digit_sel.
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [9:0] number,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] segments,
    output logic [2:0] digit_enable
);

    // Input register
    logic       a_valid_reg;
    logic [1:0] a_kind_reg;
    logic [9:0] a_number_reg;

    // Display state
    logic [3:0] hundreds_reg;
    logic [6:0] rem_reg;
    logic       display_on_reg;
    logic [1:0] scan_pos_reg;
    logic [6:0] seg_latch_reg;

    // Result register
    logic       out_valid_reg;
    logic [6:0] segments_reg;
    logic [2:0] digit_enable_reg;

    logic                   is_set;
    logic                   is_off;
    logic                   is_tick;
    logic                   has_result;
    logic                   out_free;
    logic                   a_fire;
    logic                   in_accept;
    logic [9:0]             clamped;
    msss_pkg::hund_split_t  set_split;
    msss_pkg::digit_sel_t   sel;
    logic [1:0]             scan_pos_inc;
    logic [1:0]             scan_pos_next;
    logic [6:0]             seg_latch_next;
    logic [2:0]             enable_next;

    // Handshake
    assign is_set     = (a_kind_reg == msss_pkg::KIND_SET);
    assign is_off     = (a_kind_reg == msss_pkg::KIND_OFF);
    assign is_tick    = (a_kind_reg == msss_pkg::KIND_TICK);
    assign has_result = is_off || is_tick;
    assign out_free   = !out_valid_reg || !out_stall;
    assign a_fire     = a_valid_reg && (!has_result || out_free);
    assign in_stall   = a_valid_reg && !a_fire;
    assign in_accept  = in_valid && !in_stall;

    // Set path: saturate and split off the hundreds digit
    assign clamped   = (a_number_reg > msss_pkg::MAX_SHOWN) ? msss_pkg::MAX_SHOWN
                                                            : a_number_reg;
    assign set_split = msss_pkg::split_hundreds(clamped);

    msss_digit_sel u_digit_sel (
        .hundreds (hundreds_reg),
        .rem      (rem_reg),
        .scan_pos (scan_pos_reg),
        .sel      (sel)
    );

    // Scan advance with wrap at the digit count
    assign scan_pos_inc  = scan_pos_reg + 2'd1;
    assign scan_pos_next = (scan_pos_inc >= msss_pkg::DIGIT_COUNT) ? 2'd0 : scan_pos_inc;

    // Latch and drive for off and tick words
    always_comb
    begin
        seg_latch_next = seg_latch_reg;
        enable_next    = 3'b000;
        if (is_off || !display_on_reg)
        begin
            seg_latch_next = 7'd0;
        end
        else if (sel.lit)
        begin
            seg_latch_next = sel.seg;
            enable_next    = sel.enable;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_kind_reg   <= kind;
            a_number_reg <= number;
        end
    end

    // Display state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hundreds_reg   <= 4'd0;
            rem_reg        <= 7'd0;
            display_on_reg <= 1'b0;
            scan_pos_reg   <= msss_pkg::POS_UNITS;
            seg_latch_reg  <= 7'd0;
        end
        else if (a_fire)
        begin
            if (is_set)
            begin
                hundreds_reg   <= set_split.hundreds;
                rem_reg        <= set_split.rem;
                display_on_reg <= 1'b1;
            end
            else if (is_off)
            begin
                hundreds_reg   <= 4'd0;
                rem_reg        <= 7'd0;
                display_on_reg <= 1'b0;
                seg_latch_reg  <= seg_latch_next;
            end
            else if (is_tick)
            begin
                seg_latch_reg <= seg_latch_next;
                scan_pos_reg  <= display_on_reg ? scan_pos_next : msss_pkg::POS_UNITS;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= a_fire && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && a_fire && has_result)
        begin
            segments_reg     <= seg_latch_next;
            digit_enable_reg <= enable_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = segments_reg;
    assign digit_enable = digit_enable_reg;

endmodule

// ===== sv/msss_digit_sel.sv =====
// Picks the digit for the current scan position, blanks leading zeros and
// looks up its glyph. Depends on msss_pkg.
`timescale 1ns / 1ps

module msss_digit_sel (
    input  logic [3:0]              hundreds,
    input  logic [6:0]              rem,
    input  logic [1:0]              scan_pos,
    output msss_pkg::digit_sel_t    sel
);

    msss_pkg::tens_split_t split;
    logic [3:0]            digit;
    logic                  lit;
    logic [2:0]            enable;

    assign split = msss_pkg::split_tens(rem);

    // Position decode; tens and hundreds blank when they would be leading zeros
    always_comb
    begin
        unique case (scan_pos)
            msss_pkg::POS_UNITS:
            begin
                digit  = split.units;
                lit    = 1'b1;
                enable = msss_pkg::EN_UNITS;
            end
            msss_pkg::POS_TENS:
            begin
                digit  = split.tens;
                lit    = (hundreds != 4'd0) || (split.tens != 4'd0);
                enable = msss_pkg::EN_TENS;
            end
            default:
            begin
                digit  = hundreds;
                lit    = (hundreds != 4'd0);
                enable = msss_pkg::EN_HUNDREDS;
            end
        endcase
    end

    assign sel.lit    = lit;
    assign sel.enable = lit ? enable : 3'b000;
    assign sel.seg    = msss_pkg::seg_lookup(digit);

endmodule

// ===== sv/msss_checker.sv =====
// Port-level checks on the scanner's output channel, bound to the top level.
// Depends on multiplexed_seven_segment_scanner_core_defines.svh.
`timescale 1ns / 1ps
`include "multiplexed_seven_segment_scanner_core_defines.svh"

module msss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [6:0] segments,
    input logic [2:0] digit_enable
);

    // Never more than one digit driven
    `MSSS_ASSERT_NOW(a_one_digit, clk, rst_n, out_valid, $onehot0(digit_enable), "two digits driven at once")

    // Hundreds digit is blanked when zero, so it never shows the zero glyph
    `MSSS_ASSERT_NOW(a_no_lead_zero, clk, rst_n, out_valid && digit_enable[2], segments != 7'h40, "leading zero shown on hundreds")

    // A stalled result stays put
    `MSSS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(segments) && $stable(digit_enable), "stalled result changed")

endmodule

bind multiplexed_seven_segment_scanner_core msss_checker u_msss_checker (.*);

// ===== tb/multiplexed_seven_segment_scanner_core_test.sv =====
// Self-checking testbench for the three-digit seven-segment display scanner.
// Depends on msss_pkg and multiplexed_seven_segment_scanner_core.
`timescale 1ns / 1ps

module multiplexed_seven_segment_scanner_core_test;

    // Unused kind code, dropped by the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    // Active-low glyphs, bits 0-5 are a-f, bit 6 is g
    localparam logic [6:0] GLYPH [10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                          7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

    typedef struct packed {
        logic [6:0] seg;
        logic [2:0] en;
    } scan_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] kind = msss_pkg::KIND_TICK;
    logic [9:0] number = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] segments;
    logic [2:0] digit_enable;

    // Predictor state
    logic [9:0] shown_value = '0;
    logic       display_on = 1'b0;
    logic [1:0] scan_pos = msss_pkg::POS_UNITS;
    logic [6:0] seg_latch = '0;

    scan_word_t expected_words[$];
    int         error_count = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    multiplexed_seven_segment_scanner_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .number       (number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .segments     (segments),
        .digit_enable (digit_enable)
    );

    always #2 clk = ~clk;

    // Update the scanner state for one taken word; queue the result it causes
    task automatic scan_predict(input logic [1:0] k, input logic [9:0] n);
        scan_word_t res;
        int         v;
        v = int'(shown_value);
        res.en = 3'b000;
        case (k)
            msss_pkg::KIND_SET:
            begin
                shown_value = (n > msss_pkg::MAX_SHOWN) ? msss_pkg::MAX_SHOWN : n;
                display_on = 1'b1;
            end
            msss_pkg::KIND_OFF:
            begin
                display_on = 1'b0;
                shown_value = '0;
                seg_latch = '0;
                res.seg = '0;
                expected_words.push_back(res);
            end
            msss_pkg::KIND_TICK:
            begin
                if (!display_on) begin
                    seg_latch = '0;
                    scan_pos = msss_pkg::POS_UNITS;
                end
                else begin
                    if (scan_pos == msss_pkg::POS_UNITS) begin
                        seg_latch = GLYPH[v % 10];
                        res.en = msss_pkg::EN_UNITS;
                    end
                    else if (scan_pos == msss_pkg::POS_TENS) begin
                        if (v >= 10) begin
                            seg_latch = GLYPH[(v / 10) % 10];
                            res.en = msss_pkg::EN_TENS;
                        end
                    end
                    else if (v >= 100) begin
                        seg_latch = GLYPH[v / 100];
                        res.en = msss_pkg::EN_HUNDREDS;
                    end
                    scan_pos = (scan_pos + 2'd1 >= msss_pkg::DIGIT_COUNT) ?
                               msss_pkg::POS_UNITS : scan_pos + 2'd1;
                end
                res.seg = seg_latch;
                expected_words.push_back(res);
            end
            default:
            begin
                // unused kind: no state change, no result
            end
        endcase
    endtask

    // Send one word; called at a rising edge, returns at the edge that took it
    task automatic send_word(input logic [1:0] k, input logic [9:0] n);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            kind <= 2'($urandom);
            number <= 10'($urandom);
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        number <= n;
        do
            @(posedge clk);
        while (in_stall);
        scan_predict(k, n);
    endtask

    // Receiver stall pattern
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result checker and run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: expected none, actual seg %h en %b",
                         $time, segments, digit_enable);
                error_count++;
            end
            else begin
                scan_word_t exp_w;
                exp_w = expected_words.pop_front();
                if (segments !== exp_w.seg) begin
                    $display("%0t segments mismatch: expected %h actual %h",
                             $time, exp_w.seg, segments);
                    error_count++;
                end
                if (digit_enable !== exp_w.en) begin
                    $display("%0t digit_enable mismatch: expected %b actual %b",
                             $time, exp_w.en, digit_enable);
                    error_count++;
                end
            end
        end
    end

    // Directed: disabled ticks, blanking, saturation, off, unused kind
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(KIND_UNUSED, 10'h3FF);
        send_word(msss_pkg::KIND_SET, 10'd0);
        repeat (4) send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(msss_pkg::KIND_SET, 10'd1023);
        repeat (3) send_word(msss_pkg::KIND_TICK, 10'h2AA);
        send_word(msss_pkg::KIND_SET, 10'd7);
        send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(msss_pkg::KIND_TICK, 10'd0);
        // off keeps the scan position, the next tick while off resets it
        send_word(msss_pkg::KIND_OFF, 10'h155);
        send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(msss_pkg::KIND_SET, 10'd100);
        repeat (3) send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(msss_pkg::KIND_SET, 10'd1000);
        send_word(msss_pkg::KIND_SET, 10'd512);
        send_word(msss_pkg::KIND_TICK, 10'd0);
        send_word(msss_pkg::KIND_SET, 10'd85);
        send_word(msss_pkg::KIND_TICK, 10'd0);
    endtask

    // Random number drawn from each digit-count range, the saturating range or the full 10-bit range
    function automatic logic [9:0] pick_number();
        case ($urandom_range(4))
            0:       return 10'($urandom_range(9));
            1:       return 10'($urandom_range(99, 10));
            2:       return 10'($urandom_range(999, 100));
            3:       return 10'($urandom_range(1023, 1000));
            default: return 10'($urandom);
        endcase
    endfunction

    // Random traffic: mostly ticks on a lit display, some sets, offs and noise
    task automatic test_random(input int words, input int idle_pct, input int stall_p);
        int sent;
        int r;
        sent = 0;
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        while (sent < words) begin
            r = $urandom_range(99);
            if (r < 68) begin
                send_word(msss_pkg::KIND_TICK, 10'($urandom));
                sent++;
            end
            else if (r < 88) begin
                send_word(msss_pkg::KIND_SET, pick_number());
                sent++;
            end
            else if (r < 95) begin
                send_word(msss_pkg::KIND_OFF, 10'($urandom));
                sent++;
            end
            else
                send_word(KIND_UNUSED, 10'($urandom));
        end
    endtask

    // Idle the input, then wait for all queued results
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(312, 0, 0);
        test_random(312, 74, 0);
        test_random(312, 0, 74);
        test_random(312, 16, 16);
        drain();
        stall_pct = 0;
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== multiplexed_seven_segment_scanner_core.f =====
+incdir+sv
sv/msss_pkg.sv
sv/msss_digit_sel.sv
sv/multiplexed_seven_segment_scanner_core.sv
sv/msss_checker.sv
tb/multiplexed_seven_segment_scanner_core_test.sv
